// File: sv/sbil_pkg.sv
// ----------------------------------------------------------------------------
// sbil_pkg
// Shared codes, types and the ready banner table of the serial boot loader.
// ----------------------------------------------------------------------------
package sbil_pkg;

  // input actions
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_BYTE  = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_TX    = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_JUMP  = 2'd2;

  // protocol phases
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_MAGIC   = 3'd1;
  localparam logic [2:0] PH_LENGTH  = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_DONE    = 3'd4;

  // result bursts caused by one input item
  localparam logic [2:0] BURST_BANNER         = 3'd0;
  localparam logic [2:0] BURST_ACK_JUMP       = 3'd1;
  localparam logic [2:0] BURST_WRITE          = 3'd2;
  localparam logic [2:0] BURST_WRITE_ACK_JUMP = 3'd3;
  localparam logic [2:0] BURST_JUMP           = 3'd4;

  // configuration register indexes
  localparam logic CFG_TIMEOUT   = 1'b0;
  localparam logic CFG_LOAD_BASE = 1'b1;

  localparam logic [7:0]  MAGIC_BYTE      = 8'h42;
  localparam logic [7:0]  ACK_BYTE        = 8'h4B;
  localparam logic [3:0]  BANNER_LAST     = 4'd13;
  localparam logic [25:0] TIMEOUT_RESET   = 26'd50000000;
  localparam logic [31:0] LOAD_BASE_RESET = 32'h2000_0000;

  typedef struct packed {
    logic [2:0]  burst;
    logic [31:0] wr_addr;
    logic [31:0] jump_addr;
    logic [7:0]  data;
  } burst_t;

  // ready banner: CR LF, the text BOOT_READY, CR LF
  function automatic logic [7:0] banner_char(input logic [3:0] i);
    logic [7:0] c;
    unique case (i)
      4'd0:    c = 8'h0D;
      4'd1:    c = 8'h0A;
      4'd2:    c = 8'h42;
      4'd3:    c = 8'h4F;
      4'd4:    c = 8'h4F;
      4'd5:    c = 8'h54;
      4'd6:    c = 8'h5F;
      4'd7:    c = 8'h52;
      4'd8:    c = 8'h45;
      4'd9:    c = 8'h41;
      4'd10:   c = 8'h44;
      4'd11:   c = 8'h59;
      4'd12:   c = 8'h0D;
      4'd13:   c = 8'h0A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: sv/sbil_emit.sv
// ----------------------------------------------------------------------------
// sbil_emit
// Plays out the results of one burst, one per output transfer.
// ----------------------------------------------------------------------------
module sbil_emit (
  input  logic            clk,
  input  logic            rst,
  input  logic            pend_valid,
  input  sbil_pkg::burst_t pend,
  output logic            take,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [47:0]     m_tdata,   // tx_byte[7:0], mem_address[39:8], mem_byte[47:40]
  output logic [1:0]      m_tuser,   // kind
  output logic            m_tlast
);
  import sbil_pkg::*;

  logic       busy;
  burst_t     cur;
  logic [3:0] idx;

  logic [1:0]  kind;
  logic [7:0]  tx_byte;
  logic [31:0] mem_address;
  logic [7:0]  mem_byte;
  logic        last;
  logic        done;

  // decode the current result of the burst
  always_comb begin
    kind        = KIND_TX;
    tx_byte     = 8'h00;
    mem_address = 32'h0;
    mem_byte    = 8'h00;
    last        = 1'b0;
    unique case (cur.burst)
      BURST_BANNER: begin
        tx_byte = banner_char(idx);
        last    = (idx == BANNER_LAST);
      end
      BURST_ACK_JUMP: begin
        if (idx == 4'd0) begin
          tx_byte = ACK_BYTE;
        end else begin
          kind        = KIND_JUMP;
          mem_address = cur.jump_addr;
          last        = 1'b1;
        end
      end
      BURST_WRITE: begin
        kind        = KIND_WRITE;
        mem_address = cur.wr_addr;
        mem_byte    = cur.data;
        last        = 1'b1;
      end
      BURST_WRITE_ACK_JUMP: begin
        if (idx == 4'd0) begin
          kind        = KIND_WRITE;
          mem_address = cur.wr_addr;
          mem_byte    = cur.data;
        end else if (idx == 4'd1) begin
          tx_byte = ACK_BYTE;
        end else begin
          kind        = KIND_JUMP;
          mem_address = cur.jump_addr;
          last        = 1'b1;
        end
      end
      BURST_JUMP: begin
        kind        = KIND_JUMP;
        mem_address = cur.jump_addr;
        last        = 1'b1;
      end
      default: begin
        last = 1'b1;
      end
    endcase
  end

  assign m_tvalid = busy;
  assign m_tdata  = {mem_byte, mem_address, tx_byte};
  assign m_tuser  = kind;
  assign m_tlast  = last;

  // next burst may load when idle or when the final result transfers now
  assign done = busy && m_tready && last;
  assign take = pend_valid && (!busy || done);

  // burst sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 4'd0;
    end else if (take) begin
      busy <= 1'b1;
      idx  <= 4'd0;
    end else if (done) begin
      busy <= 1'b0;
      idx  <= 4'd0;
    end else if (busy && m_tready) begin
      idx <= idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= pend;
    end
  end

endmodule

// File: sv/serial_boot_image_loader.sv
// ----------------------------------------------------------------------------
// serial_boot_image_loader
// Protocol engine of a serial boot loader: banner, magic byte, length, payload.
// ----------------------------------------------------------------------------
// Each accepted item updates the protocol state in the cycle it is taken, so
// items are accepted one per cycle as long as results drain. An item that
// causes results hands a burst descriptor to a one-deep holding register; the
// emitter then plays the burst out one result per transfer: 14 for start, one
// or three for a payload byte, two for a finishing length, one for a timeout.
// Throughput is thus bounded by the output side: the input stalls only while
// a burst waits behind another that is still being transferred.
module serial_boot_image_loader (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte
  input  logic [1:0]  s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // tx_byte[7:0], mem_address[39:8], mem_byte[47:40]
  output logic [1:0]  m_tuser,   // kind
  output logic        m_tlast
);
  import sbil_pkg::*;

  // configuration
  logic [25:0] timeout_limit;
  logic [31:0] load_base;

  // protocol state
  logic [2:0]  phase,           phase_next;
  logic [25:0] wait_count,      wait_count_next;
  logic [1:0]  len_idx,         len_idx_next;
  logic [31:0] image_length,    image_length_next;
  logic [30:0] bytes_remaining, bytes_remaining_next;
  logic [31:0] write_address,   write_address_next;

  // burst holding register
  logic   pend_valid;
  burst_t pend, pend_next;
  logic   emit_burst;
  logic   take;
  logic   accept;

  logic [25:0] wait_inc;
  logic [31:0] full_length;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = !pend_valid || take;
  assign wait_inc = wait_count + 26'd1;
  assign full_length = {s_tdata, image_length[23:0]};

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= TIMEOUT_RESET;
      load_base     <= LOAD_BASE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIMEOUT:   timeout_limit <= cfg_data[25:0];
        CFG_LOAD_BASE: load_base     <= cfg_data;
        default:       ;
      endcase
    end
  end

  // protocol step for one item
  always_comb begin
    phase_next           = phase;
    wait_count_next      = wait_count;
    len_idx_next         = len_idx;
    image_length_next    = image_length;
    bytes_remaining_next = bytes_remaining;
    write_address_next   = write_address;
    emit_burst           = 1'b0;
    pend_next.burst      = BURST_BANNER;
    pend_next.wr_addr    = write_address;
    pend_next.jump_addr  = load_base;
    pend_next.data       = s_tdata;
    priority if (s_tuser == ACT_START) begin
      emit_burst           = 1'b1;
      pend_next.burst      = BURST_BANNER;
      phase_next           = PH_MAGIC;
      wait_count_next      = 26'd0;
      len_idx_next         = 2'd0;
      image_length_next    = 32'h0;
      bytes_remaining_next = 31'h0;
      write_address_next   = 32'h0;
    end else if (s_tuser == ACT_BYTE) begin
      if (phase == PH_MAGIC) begin
        if (s_tdata == MAGIC_BYTE) begin
          phase_next        = PH_LENGTH;
          len_idx_next      = 2'd0;
          image_length_next = 32'h0;
        end
      end else if (phase == PH_LENGTH) begin
        len_idx_next = len_idx + 2'd1;
        unique case (len_idx)
          2'd0:    image_length_next = {image_length[31:8],  s_tdata};
          2'd1:    image_length_next = {image_length[31:16], s_tdata, image_length[7:0]};
          2'd2:    image_length_next = {image_length[31:24], s_tdata, image_length[15:0]};
          default: image_length_next = full_length;
        endcase
        // fourth length byte: start payload or finish at once
        if (len_idx == 2'd3) begin
          if (full_length[31] || (full_length[30:0] == 31'h0)) begin
            emit_burst      = 1'b1;
            pend_next.burst = BURST_ACK_JUMP;
            phase_next      = PH_DONE;
          end else begin
            bytes_remaining_next = full_length[30:0];
            write_address_next   = load_base;
            phase_next           = PH_PAYLOAD;
          end
        end
      end else if (phase == PH_PAYLOAD) begin
        emit_burst           = 1'b1;
        pend_next.burst      = BURST_WRITE;
        write_address_next   = write_address + 32'd1;
        bytes_remaining_next = bytes_remaining - 31'd1;
        if (bytes_remaining == 31'd1) begin
          pend_next.burst = BURST_WRITE_ACK_JUMP;
          phase_next      = PH_DONE;
        end
      end
    end else if (s_tuser == ACT_TICK) begin
      if (phase == PH_MAGIC) begin
        wait_count_next = wait_inc;
        if (wait_inc >= timeout_limit) begin
          emit_burst      = 1'b1;
          pend_next.burst = BURST_JUMP;
          phase_next      = PH_DONE;
        end
      end
    end else begin
      // spare action code: ignored
    end
  end

  // protocol state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      wait_count      <= 26'd0;
      len_idx         <= 2'd0;
      image_length    <= 32'h0;
      bytes_remaining <= 31'h0;
      write_address   <= 32'h0;
    end else if (accept) begin
      phase           <= phase_next;
      wait_count      <= wait_count_next;
      len_idx         <= len_idx_next;
      image_length    <= image_length_next;
      bytes_remaining <= bytes_remaining_next;
      write_address   <= write_address_next;
    end
  end

  // burst holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (accept && emit_burst) begin
      pend_valid <= 1'b1;
    end else if (take) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit_burst) begin
      pend <= pend_next;
    end
  end

  sbil_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .pend_valid (pend_valid),
    .pend       (pend),
    .take       (take),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule
